// ----- design/pts_pkg.sv -----
// ----------------------------------------------------------------------------
// pts_pkg
// Shared widths, operation codes and controller/datapath command and status
// types for the periodic task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

   localparam int NOW_W    = 64;
   localparam int PERIOD_W = 32;
   localparam int FIRE_W   = 16;
   localparam int COUNT_W  = 5;

   localparam logic OP_TICK     = 1'b0;
   localparam logic OP_REGISTER = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture the accepted request
      logic reg_write;   // append a task if there is room
      logic scan_start;  // clear mask and scan counter
      logic scan_step;   // issue the next table read
      logic rsp_load;    // load the response register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic op_register;
      logic scan_done;
   } status_type;

endpackage

// ----- design/pts_req_if.sv -----
// ----------------------------------------------------------------------------
// pts_req_if
// Request channel: operation, current time and task interval.
// ----------------------------------------------------------------------------
interface pts_req_if;
   import pts_pkg::*;

   logic                valid;
   logic                ready;
   logic                operation;
   logic [NOW_W-1:0]    now_ms;
   logic [PERIOD_W-1:0] period_ms;

   modport source (output valid, output operation, output now_ms, output period_ms,
                   input ready);
   modport sink   (input valid, input operation, input now_ms, input period_ms,
                   output ready);
endinterface

// ----- design/pts_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pts_rsp_if
// Response channel: fire mask, accept flag and task count.
// ----------------------------------------------------------------------------
interface pts_rsp_if;
   import pts_pkg::*;

   logic               valid;
   logic               ready;
   logic [FIRE_W-1:0]  fire_mask;
   logic               accepted;
   logic [COUNT_W-1:0] tasks_in_use;

   modport source (output valid, output fire_mask, output accepted, output tasks_in_use,
                   input ready);
   modport sink   (input valid, input fire_mask, input accepted, input tasks_in_use,
                   output ready);
endinterface

// ----- design/pts_datapath.sv -----
// ----------------------------------------------------------------------------
// pts_datapath
// Task table memories, task count, scan pipeline (read, then compare and
// write back) and the response payload register.
// ----------------------------------------------------------------------------
module pts_datapath #(
   parameter int MAX_TASKS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pts_pkg::cmd_type              cmd,
   output pts_pkg::status_type           status,
   input  logic                          req_operation,
   input  logic [pts_pkg::NOW_W-1:0]     req_now_ms,
   input  logic [pts_pkg::PERIOD_W-1:0]  req_period_ms,
   output logic [pts_pkg::FIRE_W-1:0]    rsp_fire_mask,
   output logic                          rsp_accepted,
   output logic [pts_pkg::COUNT_W-1:0]   rsp_tasks_in_use
);
   import pts_pkg::*;

   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TASKS);

   // task table
   logic [NOW_W-1:0]    last_run_mem [MAX_TASKS];
   logic [PERIOD_W-1:0] period_mem   [MAX_TASKS];
   logic [NOW_W-1:0]    last_rd_ff;
   logic [PERIOD_W-1:0] period_rd_ff;

   // captured request
   logic                op_ff,     op_in;
   logic [NOW_W-1:0]    now_ff,    now_in;
   logic [PERIOD_W-1:0] period_ff, period_in;

   logic [CNT_W-1:0]    total_ff,    total_in;
   logic [CNT_W-1:0]    scan_cnt_ff, scan_cnt_in;
   logic                cmp_vld_ff,  cmp_vld_in;
   logic [IDX_W-1:0]    cmp_idx_ff,  cmp_idx_in;
   logic [FIRE_W-1:0]   mask_ff,     mask_in;
   logic                ok_ff,       ok_in;

   logic [FIRE_W-1:0]   rsp_mask_ff,  rsp_mask_in;
   logic                rsp_ok_ff,    rsp_ok_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic                room;
   logic                issue;
   logic [IDX_W-1:0]    rd_addr;
   logic [NOW_W-1:0]    elapsed;
   logic                due;
   logic                mem_we;
   logic                per_we;
   logic [IDX_W-1:0]    wr_addr;

   assign room    = (total_ff < MAX_CNT);
   assign issue   = cmd.scan_step && (scan_cnt_ff < total_ff);
   assign rd_addr = scan_cnt_ff[IDX_W-1:0];
   // unsigned wrap-around elapsed time
   assign elapsed = now_ff - last_rd_ff;
   assign due     = cmp_vld_ff && (elapsed >= {{(NOW_W-PERIOD_W){1'b0}}, period_rd_ff});

   assign per_we  = cmd.reg_write && room;
   assign mem_we  = per_we || due;
   assign wr_addr = per_we ? total_ff[IDX_W-1:0] : cmp_idx_ff;

   always_comb begin
      op_in     = op_ff;
      now_in    = now_ff;
      period_in = period_ff;
      if (cmd.load) begin
         op_in     = req_operation;
         now_in    = req_now_ms;
         period_in = req_period_ms;
      end
   end

   always_comb begin
      total_in    = total_ff;
      ok_in       = ok_ff;
      scan_cnt_in = scan_cnt_ff;
      cmp_vld_in  = issue;
      cmp_idx_in  = rd_addr;
      mask_in     = mask_ff;
      if (cmd.reg_write) begin
         ok_in = room;
         if (room) begin
            total_in = total_ff + CNT_W'(1);
         end
      end
      if (cmd.scan_start) begin
         ok_in       = 1'b1;
         mask_in     = '0;
         scan_cnt_in = '0;
      end else if (issue) begin
         scan_cnt_in = scan_cnt_ff + CNT_W'(1);
      end
      // tasks past the mask width are still updated but have no bit
      if (due) begin
         mask_in = mask_ff | (FIRE_W'(1) << cmp_idx_ff);
      end
   end

   always_comb begin
      rsp_mask_in  = rsp_mask_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_count_in = rsp_count_ff;
      if (cmd.rsp_load) begin
         rsp_mask_in  = (op_ff == OP_REGISTER) ? '0 : mask_ff;
         rsp_ok_in    = ok_ff;
         rsp_count_in = COUNT_W'(total_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         last_run_mem[wr_addr] <= now_ff;
      end
      if (per_we) begin
         period_mem[wr_addr] <= period_ff;
      end
      last_rd_ff   <= last_run_mem[rd_addr];
      period_rd_ff <= period_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         total_ff   <= total_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      now_ff       <= now_in;
      period_ff    <= period_in;
      scan_cnt_ff  <= scan_cnt_in;
      cmp_idx_ff   <= cmp_idx_in;
      mask_ff      <= mask_in;
      ok_ff        <= ok_in;
      rsp_mask_ff  <= rsp_mask_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign status.op_register = (op_ff == OP_REGISTER);
   assign status.scan_done   = (scan_cnt_ff >= total_ff) && !cmp_vld_ff;

   assign rsp_fire_mask    = rsp_mask_ff;
   assign rsp_accepted     = rsp_ok_ff;
   assign rsp_tasks_in_use = rsp_count_ff;

endmodule

// ----- design/pts_ctrl.sv -----
// ----------------------------------------------------------------------------
// pts_ctrl
// Sequencer: takes one request, runs the register or scan operation in the
// datapath, then hands the result to the response register.
// ----------------------------------------------------------------------------
module pts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pts_pkg::cmd_type    cmd,
   input  pts_pkg::status_type status
);
   import pts_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   // response register frees up in the same cycle as its transfer
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_ready      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.op_register) begin
               cmd.reg_write = 1'b1;
               state_in      = ST_DONE;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- design/periodic_task_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// periodic_task_scheduler_core
// Table of periodic tasks; register requests append a task, tick requests
// return the mask of tasks that are due and restamp them.
// ----------------------------------------------------------------------------
// A register request passes through the exec and done states. A tick request
// walks the table through one read port, one entry per cycle, with the
// compare and write-back in the cycle after each read, until every entry in
// use has been compared. The next request can be taken in the cycle after
// the result is loaded. Only one request is in work at a time; a new request
// is taken while the previous result still waits in the response register,
// and a result that cannot be loaded holds the request behind it.
module periodic_task_scheduler_core #(
   parameter int MAX_TASKS = 16
) (
   input logic        clock,
   input logic        reset,
   pts_req_if.sink    req_chan,
   pts_rsp_if.source  rsp_chan
);
   import pts_pkg::*;

   cmd_type    cmd;
   status_type status;

   pts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   pts_datapath #(
      .MAX_TASKS (MAX_TASKS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_chan.operation),
      .req_now_ms       (req_chan.now_ms),
      .req_period_ms    (req_chan.period_ms),
      .rsp_fire_mask    (rsp_chan.fire_mask),
      .rsp_accepted     (rsp_chan.accepted),
      .rsp_tasks_in_use (rsp_chan.tasks_in_use)
   );

endmodule

// ----- bench/pts_sched_checker.sv -----
// ----------------------------------------------------------------------------
// pts_sched_checker
// Watches the request and response channels of the task scheduler, keeps its
// own copy of the task table to work out the response each request should
// produce, and checks responses in order, field by field.
// ----------------------------------------------------------------------------
module pts_sched_checker #(
   parameter int MAX_TASKS = 16
) (
   input  logic clock,
   input  logic reset,
   pts_req_if   req_mon,
   pts_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import pts_pkg::*;

   typedef struct packed {
      logic [FIRE_W-1:0]  fire_mask;
      logic               accepted;
      logic [COUNT_W-1:0] tasks_in_use;
   } sched_result_type;

   logic [NOW_W-1:0]    last_run      [MAX_TASKS];
   logic [PERIOD_W-1:0] task_interval [MAX_TASKS];
   int unsigned         task_count;
   sched_result_type    due_q [$];

   initial begin
      fail_count = 0;
      pending    = 0;
      task_count = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] scheduler mismatch: %s", $time, msg);
      fail_count++;
   endtask

   // Applies one request to the shadow table and returns the response it earns.
   function automatic sched_result_type schedule_request(input logic op,
                                                         input logic [NOW_W-1:0] now,
                                                         input logic [PERIOD_W-1:0] period);
      sched_result_type res;
      logic [NOW_W-1:0] elapsed;
      res.fire_mask = '0;
      res.accepted  = 1'b1;
      if (op == OP_REGISTER) begin
         if (task_count < MAX_TASKS) begin
            last_run[task_count]      = now;
            task_interval[task_count] = period;
            task_count++;
         end else begin
            res.accepted = 1'b0;
         end
      end else begin
         for (int i = 0; i < task_count; i++) begin
            // wrapping difference: a clock that went backwards looks huge
            elapsed = now - last_run[i];
            if (elapsed >= NOW_W'(task_interval[i])) begin
               if (i < FIRE_W) res.fire_mask[i] = 1'b1;
               last_run[i] = now;
            end
         end
      end
      res.tasks_in_use = COUNT_W'(task_count);
      return res;
   endfunction

   always @(posedge clock) begin
      sched_result_type want;
      if (reset) begin
         due_q.delete();
         task_count = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            due_q.push_back(schedule_request(req_mon.operation, req_mon.now_ms,
                                             req_mon.period_ms));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_q.size() == 0) begin
               report_mismatch("response transfer with no request outstanding");
            end else begin
               want = due_q.pop_front();
               if (rsp_mon.fire_mask !== want.fire_mask)
                  report_mismatch($sformatf("fire_mask got %h want %h",
                                            rsp_mon.fire_mask, want.fire_mask));
               if (rsp_mon.accepted !== want.accepted)
                  report_mismatch($sformatf("accepted got %b want %b",
                                            rsp_mon.accepted, want.accepted));
               if (rsp_mon.tasks_in_use !== want.tasks_in_use)
                  report_mismatch($sformatf("tasks_in_use got %0d want %0d",
                                            rsp_mon.tasks_in_use, want.tasks_in_use));
            end
         end
      end
      pending <= due_q.size();
   end

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives register and tick requests into the task scheduler: a directed run
// over time and interval extremes and wrap-around, then random traffic on a
// wandering clock and a full table. The receiver stalls at random and once holds
// off long enough to back up the request channel.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pts_pkg::*;

   localparam int LIMIT_CYCLES = 200_000;
   localparam int RANDOM_ITEMS = 900;
   localparam int HOLD_START   = 1500;
   localparam int HOLD_LEN     = 300;
   localparam int CALM_START   = 4000;
   localparam int CALM_END     = 6000;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   pending;
   int   cycle_count = 0;

   pts_req_if req_bus ();
   pts_rsp_if rsp_bus ();

   periodic_task_scheduler_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   pts_sched_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin : watchdog
      @(posedge clock);
      while (cycle_count < LIMIT_CYCLES) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   // Response side: sparse random stalls, a quiet window, and one long hold-off.
   initial begin : rsp_drain
      int cyc;
      cyc = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) begin
            rsp_bus.ready <= 1'b0;
         end else if (cyc >= CALM_START && cyc < CALM_END) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= 6);
         end
      end
   end

   task automatic send_request(input logic op, input logic [NOW_W-1:0] now,
                               input logic [PERIOD_W-1:0] period, input bit allow_gap);
      if (allow_gap && $urandom_range(0, 99) < 6) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.now_ms    <= now;
      req_bus.period_ms <= period;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   function automatic logic [PERIOD_W-1:0] pick_period();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return '0;
      if (r < 65) return PERIOD_W'($urandom_range(1, 120));
      if (r < 80) return PERIOD_W'($urandom);
      return 32'hFFFF_FFFF - PERIOD_W'($urandom_range(0, 3));
   endfunction

   // Mostly small steps forward, with stalls, steps back, jumps and wrap.
   function automatic logic [NOW_W-1:0] next_wall(input logic [NOW_W-1:0] w);
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return w + NOW_W'($urandom_range(0, 40));
      if (r < 70) return w;
      if (r < 80) return w - NOW_W'($urandom_range(1, 30));
      if (r < 88) return w + NOW_W'($urandom);
      if (r < 94) return {$urandom, $urandom};
      return 64'hFFFF_FFFF_FFFF_FFFF - NOW_W'($urandom_range(0, 50));
   endfunction

   initial begin : stimulus
      logic [NOW_W-1:0] wall;
      logic             op;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.operation <= OP_TICK;
      req_bus.now_ms    <= '0;
      req_bus.period_ms <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, zero and max interval, time extremes, going
      // backwards, exact boundaries, wrap past zero
      send_request(OP_TICK,     64'd0,   32'hFFFF_FFFF, 1'b1);
      send_request(OP_REGISTER, 64'd0,   32'd0,         1'b1);
      send_request(OP_REGISTER, '1,      '1,            1'b1);
      send_request(OP_REGISTER, 64'd100, 32'd10,        1'b1);
      send_request(OP_TICK,     64'd5,   32'd0,         1'b1);
      send_request(OP_TICK,     64'd5,   32'd0,         1'b1);
      send_request(OP_TICK,     64'd15,  '1,            1'b1);
      send_request(OP_TICK,     64'd14,  32'd0,         1'b1);
      send_request(OP_REGISTER, 64'h0000_0001_0000_0000, 32'hAAAA_AAAA, 1'b1);
      send_request(OP_REGISTER, 64'h5555_5555_5555_5555, 32'h5555_5555, 1'b1);
      send_request(OP_TICK,     64'h0000_0001_AAAA_AAA9, 32'h1234_5678, 1'b1);
      send_request(OP_TICK,     64'h0000_0001_AAAA_AAAA, 32'hEDCB_A987, 1'b1);
      send_request(OP_TICK,     64'hFFFF_FFFF_FFFF_FFFF, 32'd0,         1'b1);
      send_request(OP_TICK,     64'hFFFF_FFFF_FFFF_FFFF, 32'd0,         1'b1);
      send_request(OP_TICK,     64'd9,   32'd0,         1'b1);

      wall = 64'd1000;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         wall = next_wall(wall);
         op   = ($urandom_range(0, 99) < 12) ? OP_REGISTER : OP_TICK;
         send_request(op, wall, (op == OP_REGISTER) ? pick_period() : PERIOD_W'($urandom),
                      !(n >= 400 && n < 600));
      end

      // make sure the table is full and overflow is rejected
      repeat (17) begin
         wall = wall + 1;
         send_request(OP_REGISTER, wall, pick_period(), 1'b1);
      end
      send_request(OP_TICK, wall + 64'd200, PERIOD_W'($urandom), 1'b1);
      req_bus.valid <= 1'b0;

      do @(posedge clock); while (pending != 0);
      repeat (30) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
